[hw/rtl/mrq_pkg.sv]
`timescale 1ns / 1ps

package mrq_pkg;

    localparam logic [7:0] ACTIVE_SENSE = 8'hFE;
    localparam int unsigned FILL_W = 10;

    typedef enum logic [2:0] {
        ST_STORED     = 3'd0,
        ST_OVERWRITE  = 3'd1,
        ST_SENSE_DROP = 3'd2,
        ST_READ_OK    = 3'd3,
        ST_READ_EMPTY = 3'd4
    } rsp_status_t;

    typedef enum logic {
        REQ_RX   = 1'b0,
        REQ_READ = 1'b1
    } req_t;

    typedef enum logic {
        S_IDLE    = 1'b0,
        S_RD_WAIT = 1'b1
    } ctrl_state_t;

    typedef struct packed {
        logic accept;
        logic load_rd;
    } ctrl_cmd_t;

    typedef struct packed {
        logic read_ok;
    } dp_sts_t;

endpackage

[hw/rtl/mrq_ctrl.sv]
`timescale 1ns / 1ps

module mrq_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    output logic                m_tvalid,
    input  logic                m_tready,
    input  mrq_pkg::dp_sts_t    sts,
    output mrq_pkg::ctrl_cmd_t  cmd
);

    mrq_pkg::ctrl_state_t state_reg, state_next;
    logic                 m_valid_reg, m_valid_next;
    logic                 accept;

    assign m_tvalid = m_valid_reg;

    always_comb begin
        s_tready    = (state_reg == mrq_pkg::S_IDLE) && (!m_valid_reg || m_tready);
        accept      = s_tvalid && s_tready;
        cmd.accept  = accept;
        cmd.load_rd = (state_reg == mrq_pkg::S_RD_WAIT);
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            mrq_pkg::S_IDLE: begin
                if (accept && sts.read_ok) begin
                    state_next = mrq_pkg::S_RD_WAIT;
                end
            end
            mrq_pkg::S_RD_WAIT: begin
                state_next = mrq_pkg::S_IDLE;
            end
            default: begin
                state_next = mrq_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (accept) begin
            m_valid_next = !sts.read_ok;
        end else if (state_reg == mrq_pkg::S_RD_WAIT) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= mrq_pkg::S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_rd_wait_one_cycle: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == mrq_pkg::S_RD_WAIT |=> state_reg == mrq_pkg::S_IDLE && m_valid_reg)
        else $error("read wait did not complete in one cycle");

    a_read_holds_output: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && sts.read_ok |=> state_reg == mrq_pkg::S_RD_WAIT && !m_valid_reg)
        else $error("read accepted without entering read wait");

    a_no_accept_while_waiting: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == mrq_pkg::S_RD_WAIT |-> !cmd.accept)
        else $error("item accepted during read wait");
`endif

endmodule

[hw/rtl/mrq_datapath.sv]
`timescale 1ns / 1ps

module mrq_datapath #(
    parameter int unsigned DEPTH = 512
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  mrq_pkg::ctrl_cmd_t          cmd,
    output mrq_pkg::dp_sts_t            sts,
    input  logic                        req_type,
    input  logic [7:0]                  rx_byte,
    output logic [2:0]                  status,
    output logic [7:0]                  read_byte,
    output logic [mrq_pkg::FILL_W-1:0]  fill_level
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    logic [7:0] mem [DEPTH];

    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [7:0]       rd_data_reg;

    mrq_pkg::rsp_status_t         status_reg;
    logic [7:0]                   byte_reg;
    logic [mrq_pkg::FILL_W-1:0]   fill_reg;

    mrq_pkg::rsp_status_t         code;
    logic                         full;
    logic                         empty;
    logic                         do_write;
    logic [mrq_pkg::FILL_W+CNT_W-1:0] fill_ext;

    function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
        bump = (p == PTR_LAST) ? '0 : p + PTR_W'(1);
    endfunction

    assign full       = (count_reg == CNT_FULL);
    assign empty      = (count_reg == '0);
    assign status     = status_reg;
    assign read_byte  = byte_reg;
    assign fill_level = fill_reg;

    always_comb begin
        if (mrq_pkg::req_t'(req_type) == mrq_pkg::REQ_RX) begin
            if (!full) begin
                code = mrq_pkg::ST_STORED;
            end else if (rx_byte != mrq_pkg::ACTIVE_SENSE) begin
                code = mrq_pkg::ST_OVERWRITE;
            end else begin
                code = mrq_pkg::ST_SENSE_DROP;
            end
        end else begin
            code = empty ? mrq_pkg::ST_READ_EMPTY : mrq_pkg::ST_READ_OK;
        end
        sts.read_ok = (code == mrq_pkg::ST_READ_OK);
        do_write    = cmd.accept &&
                      (code == mrq_pkg::ST_STORED || code == mrq_pkg::ST_OVERWRITE);
    end

    always_comb begin
        rd_ptr_next = rd_ptr_reg;
        wr_ptr_next = wr_ptr_reg;
        count_next  = count_reg;
        if (cmd.accept) begin
            case (code)
                mrq_pkg::ST_STORED: begin
                    wr_ptr_next = bump(wr_ptr_reg);
                    count_next  = count_reg + CNT_W'(1);
                end
                mrq_pkg::ST_OVERWRITE: begin
                    wr_ptr_next = bump(wr_ptr_reg);
                    rd_ptr_next = bump(rd_ptr_reg);
                end
                mrq_pkg::ST_READ_OK: begin
                    rd_ptr_next = bump(rd_ptr_reg);
                    count_next  = count_reg - CNT_W'(1);
                end
                default: begin
                end
            endcase
        end
        fill_ext = {{mrq_pkg::FILL_W{1'b0}}, count_next};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_ptr_reg <= '0;
            wr_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            rd_ptr_reg <= rd_ptr_next;
            wr_ptr_reg <= wr_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_write) begin
            mem[wr_ptr_reg] <= rx_byte;
        end
        if (cmd.accept && sts.read_ok) begin
            rd_data_reg <= mem[rd_ptr_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            status_reg <= code;
            byte_reg   <= '0;
            fill_reg   <= fill_ext[mrq_pkg::FILL_W-1:0];
        end else if (cmd.load_rd) begin
            byte_reg   <= rd_data_reg;
        end
    end

`ifndef NO_ASSERTIONS
    logic [CNT_W:0] chk_sum;
    logic [CNT_W:0] chk_wrap;
    assign chk_sum  = (CNT_W + 1)'(rd_ptr_reg) + (CNT_W + 1)'(count_reg);
    assign chk_wrap = (chk_sum >= (CNT_W + 1)'(DEPTH)) ? chk_sum - (CNT_W + 1)'(DEPTH)
                                                       : chk_sum;

    a_count_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_FULL)
        else $error("fill count beyond depth");

    a_pointers_consistent: assert property (@(posedge aclk) disable iff (!aresetn)
        chk_wrap == (CNT_W + 1)'(wr_ptr_reg))
        else $error("pointers disagree with fill count");

    a_overwrite_keeps_full: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.accept && code == mrq_pkg::ST_OVERWRITE |=> full)
        else $error("overwrite left the queue short of full");
`endif

endmodule

[hw/rtl/midi_receive_queue_overwrite_top.sv]
`timescale 1ns / 1ps

// channel | dir | tdata                              | tuser
// s_      | in  | [7:0] rx_byte                      | [0] req_type
// m_      | out | [7:0] read_byte, [17:8] fill_level | [2:0] status
//
// A received byte or an empty read goes straight to the result register; a
// successful read first passes the registered read port of the byte store.
// The result register frees the input side as soon as the result is taken.
// aresetn (synchronous) clears pointers, count and handshake state; the
// byte store is not cleared, so no clearing pass is needed.

module midi_receive_queue_overwrite_top #(
    parameter int unsigned DEPTH = 512
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    input  logic        s_tuser,   // [0] req_type
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [7:0] read_byte, [17:8] fill_level, zero above
    output logic [2:0]  m_tuser    // [2:0] status
);

    mrq_pkg::ctrl_cmd_t          cmd;
    mrq_pkg::dp_sts_t            sts;
    logic [7:0]                  read_byte;
    logic [mrq_pkg::FILL_W-1:0]  fill_level;

    mrq_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    mrq_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .sts        (sts),
        .req_type   (s_tuser),
        .rx_byte    (s_tdata),
        .status     (m_tuser),
        .read_byte  (read_byte),
        .fill_level (fill_level)
    );

    assign m_tdata = {6'd0, fill_level, read_byte};

endmodule
